// ----- src/crpe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpe_pkg
// Shared constants and types for the Catmull-Rom point evaluator.
// ----------------------------------------------------------------------------
package crpe_pkg;

    // Fraction bits of the Horner accumulator
    localparam int ACC_FRAC   = 16;
    // Fraction bits of the curve coordinates
    localparam int OUT_FRAC   = 8;
    // Width of a curve coordinate
    localparam int OUT_BITS   = 21;
    // Final shift: drop the halving and the extra accumulator fraction
    localparam int FIN_SH     = ACC_FRAC + 1 - OUT_FRAC;
    // Saturation limits of a curve coordinate
    localparam int OUT_MAX    = (1 << (OUT_BITS - 1)) - 1;
    localparam int OUT_MIN    = -(1 << (OUT_BITS - 1));
    // Register stages from request to result
    localparam int NUM_STAGES = 8;

    // Per-stage load strobes from the pipeline control to the datapath
    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;
    } t_pipe_ctl;

endpackage

// ----- src/crpe_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpe_if
// Valid/ready channels of the point evaluator: control point request in,
// curve point result out.
// ----------------------------------------------------------------------------

// Request: curve parameter and four control points
interface crpe_in_if #(
    parameter int COORD_BITS  = 11,
    parameter int T_FRAC_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [T_FRAC_BITS-1:0] t_param;
    logic [COORD_BITS-1:0]  p0_x;
    logic [COORD_BITS-1:0]  p0_y;
    logic [COORD_BITS-1:0]  p1_x;
    logic [COORD_BITS-1:0]  p1_y;
    logic [COORD_BITS-1:0]  p2_x;
    logic [COORD_BITS-1:0]  p2_y;
    logic [COORD_BITS-1:0]  p3_x;
    logic [COORD_BITS-1:0]  p3_y;

    modport source (
        output valid, t_param, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
        input  ready
    );
    modport sink (
        input  valid, t_param, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
        output ready
    );
endinterface

// Result: one curve point
interface crpe_out_if;
    import crpe_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] curve_x;
    logic signed [OUT_BITS-1:0] curve_y;

    modport source (
        output valid, curve_x, curve_y,
        input  ready
    );
    modport sink (
        input  valid, curve_x, curve_y,
        output ready
    );
endinterface

// ----- src/crpe_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpe_axis
// One coordinate axis of the evaluator: basis coefficients, three Horner
// steps (multiply stage, round-and-add stage), final round and saturation.
// ----------------------------------------------------------------------------
module crpe_axis #(
    parameter int COORD_BITS  = 11,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  crpe_pkg::t_pipe_ctl                  i_ctl,
    input  logic [T_FRAC_BITS-1:0]               i_t,
    input  logic [COORD_BITS-1:0]                i_q0,
    input  logic [COORD_BITS-1:0]                i_q1,
    input  logic [COORD_BITS-1:0]                i_q2,
    input  logic [COORD_BITS-1:0]                i_q3,
    output logic signed [crpe_pkg::OUT_BITS-1:0] o_coord
);
    import crpe_pkg::*;

    // Coefficient widths: |a3| <= 4M, |a2| <= 6M, |a1| <= M
    localparam int A3W   = COORD_BITS + 3;
    localparam int A2W   = COORD_BITS + 4;
    localparam int A1W   = COORD_BITS + 1;
    // Accumulator stays within 13M: sign, COORD_BITS+4 integer bits, fraction
    localparam int ACC_W = COORD_BITS + 5 + ACC_FRAC;
    localparam int TW    = T_FRAC_BITS;
    localparam int PW    = ACC_W + TW + 1;
    localparam int SHW   = ACC_W - FIN_SH;
    localparam int RW    = (SHW > OUT_BITS) ? SHW : OUT_BITS;

    localparam logic signed [PW-1:0]    HALF_T = PW'(1) << (TW - 1);
    localparam logic signed [ACC_W-1:0] HALF_F = ACC_W'(1) << (FIN_SH - 1);
    localparam logic signed [RW-1:0]    SAT_HI = RW'(OUT_MAX);
    localparam logic signed [RW-1:0]    SAT_LO = RW'(OUT_MIN);

    // Round half up by TW bits, then add the next scaled coefficient
    function automatic logic signed [ACC_W-1:0] round_add(
        input logic signed [PW-1:0]    prod,
        input logic signed [ACC_W-1:0] coef
    );
        logic signed [PW-1:0] sum;
        sum = prod + HALF_T;
        return $signed(sum[TW +: ACC_W]) + coef;
    endfunction

    // Stage registers
    logic signed [A3W-1:0]   r0_a3;
    logic signed [A2W-1:0]   r0_a2, r1_a2;
    logic signed [A1W-1:0]   r0_a1, r1_a1, r2_a1, r3_a1;
    logic [COORD_BITS-1:0]   r0_q1, r1_q1, r2_q1, r3_q1, r4_q1, r5_q1;
    logic [TW-1:0]           r0_t, r1_t, r2_t, r3_t, r4_t;
    logic signed [PW-1:0]    r1_prod, r3_prod, r5_prod;
    logic signed [ACC_W-1:0] r2_acc, r4_acc, r6_acc;
    logic signed [OUT_BITS-1:0] r7_out;

    // Next values
    logic signed [A3W-1:0]      n0_a3;
    logic signed [A2W-1:0]      n0_a2;
    logic signed [A1W-1:0]      n0_a1;
    logic signed [PW-1:0]       n1_prod, n3_prod, n5_prod;
    logic signed [ACC_W-1:0]    n2_acc, n4_acc, n6_acc;
    logic signed [OUT_BITS-1:0] n7_out;

    logic signed [A2W-1:0]   s0, s1, s2, s3;
    logic signed [ACC_W-1:0] acc0;
    logic signed [ACC_W-1:0] fsum;
    logic signed [SHW-1:0]   shv;
    logic signed [RW-1:0]    wide;

    // Stage 0: basis matrix applied to the control points
    always_comb begin
        s0    = $signed(A2W'(i_q0));
        s1    = $signed(A2W'(i_q1));
        s2    = $signed(A2W'(i_q2));
        s3    = $signed(A2W'(i_q3));
        n0_a3 = A3W'(-s0 + 3 * s1 - 3 * s2 + s3);
        n0_a2 = A2W'(2 * s0 - 5 * s1 + 4 * s2 - s3);
        n0_a1 = A1W'(s2 - s0);
    end

    // Horner steps: multiply, then round and add the next coefficient
    always_comb begin
        acc0    = ACC_W'(r0_a3) <<< ACC_FRAC;
        n1_prod = acc0 * $signed({1'b0, r0_t});
        n2_acc  = round_add(r1_prod, ACC_W'(r1_a2) <<< ACC_FRAC);
        n3_prod = r2_acc * $signed({1'b0, r2_t});
        n4_acc  = round_add(r3_prod, ACC_W'(r3_a1) <<< ACC_FRAC);
        n5_prod = r4_acc * $signed({1'b0, r4_t});
        n6_acc  = round_add(r5_prod, $signed(ACC_W'(r5_q1) << (ACC_FRAC + 1)));
    end

    // Halve, round to output fraction, saturate
    always_comb begin
        fsum = r6_acc + HALF_F;
        shv  = fsum[ACC_W-1:FIN_SH];
        wide = RW'(shv);
        if (wide > SAT_HI) begin
            n7_out = OUT_BITS'(SAT_HI);
        end else if (wide < SAT_LO) begin
            n7_out = OUT_BITS'(SAT_LO);
        end else begin
            n7_out = OUT_BITS'(wide);
        end
    end

    // Pipeline registers, loaded as requests move forward
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[0]) begin
            r0_a3 <= n0_a3;
            r0_a2 <= n0_a2;
            r0_a1 <= n0_a1;
            r0_q1 <= i_q1;
            r0_t  <= i_t;
        end
        if (i_ctl.ld[1]) begin
            r1_prod <= n1_prod;
            r1_a2   <= r0_a2;
            r1_a1   <= r0_a1;
            r1_q1   <= r0_q1;
            r1_t    <= r0_t;
        end
        if (i_ctl.ld[2]) begin
            r2_acc <= n2_acc;
            r2_a1  <= r1_a1;
            r2_q1  <= r1_q1;
            r2_t   <= r1_t;
        end
        if (i_ctl.ld[3]) begin
            r3_prod <= n3_prod;
            r3_a1   <= r2_a1;
            r3_q1   <= r2_q1;
            r3_t    <= r2_t;
        end
        if (i_ctl.ld[4]) begin
            r4_acc <= n4_acc;
            r4_q1  <= r3_q1;
            r4_t   <= r3_t;
        end
        if (i_ctl.ld[5]) begin
            r5_prod <= n5_prod;
            r5_q1   <= r4_q1;
        end
        if (i_ctl.ld[6]) begin
            r6_acc <= n6_acc;
        end
        if (i_ctl.ld[7]) begin
            r7_out <= n7_out;
        end
    end

    assign o_coord = r7_out;

endmodule

// ----- src/catmull_rom_point_eval_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_point_eval_top
// Uniform Catmull-Rom curve point evaluator, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   i_pt carries one request per handshake: curve parameter t (unsigned
//   fraction) and four control points. o_pt returns one curve point per
//   request, x and y signed with 8 fraction bits, saturated to 21 bits.
//   Requests are independent and results leave in request order.
// Depth / throughput:
//   8 register stages between the accepting edge and o_pt.valid; one
//   request per cycle sustained while the receiver stays ready. The depth
//   is set by the three Horner steps, each a multiply stage plus a
//   round-and-add stage, between the coefficient stage and the saturating
//   output register.
// Stall:
//   Each stage holds its request while the one ahead is full and held; empty
//   stages keep filling, so up to 8 requests are held when o_pt.ready stays
//   low, and nothing is dropped or repeated.
// Reset:
//   Synchronous active-low i_rst_n clears all stage valid bits; no results
//   are pending afterward.
// ----------------------------------------------------------------------------
module catmull_rom_point_eval_top #(
    parameter int COORD_BITS  = 11,
    parameter int T_FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    crpe_in_if.sink   i_pt,
    crpe_out_if.source o_pt
);
    import crpe_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] en;
    t_pipe_ctl             ctl;

    logic signed [OUT_BITS-1:0] coord_x;
    logic signed [OUT_BITS-1:0] coord_y;

    // Stage advance: a stage takes new data when empty or when it moves on
    always_comb begin
        en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_pt.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        ctl.ld[0] = en[0] && i_pt.valid;
        n_vld[0]  = en[0] ? i_pt.valid : r_vld[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            ctl.ld[k] = en[k] && r_vld[k-1];
            n_vld[k]  = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Datapath, one per axis
    crpe_axis #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_axis_x (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_t     (i_pt.t_param),
        .i_q0    (i_pt.p0_x),
        .i_q1    (i_pt.p1_x),
        .i_q2    (i_pt.p2_x),
        .i_q3    (i_pt.p3_x),
        .o_coord (coord_x)
    );

    crpe_axis #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_axis_y (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_t     (i_pt.t_param),
        .i_q0    (i_pt.p0_y),
        .i_q1    (i_pt.p1_y),
        .i_q2    (i_pt.p2_y),
        .i_q3    (i_pt.p3_y),
        .o_coord (coord_y)
    );

    // Channel outputs
    assign i_pt.ready   = en[0];
    assign o_pt.valid   = r_vld[NUM_STAGES-1];
    assign o_pt.curve_x = coord_x;
    assign o_pt.curve_y = coord_y;

endmodule

// ----- src/crpe_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpe_check
// Port-level checks of the point evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module crpe_check (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 i_in_ready,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic signed [crpe_pkg::OUT_BITS-1:0] i_curve_x,
    input logic signed [crpe_pkg::OUT_BITS-1:0] i_curve_y
);
    import crpe_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // Reset leaves no pending result
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_curve_x) && $stable(i_curve_y))
        else $error("stalled result changed or dropped");

    // Whenever the output moves, the whole pipe can take a request
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("request refused while output is free");

    // A request reaches the output after the pipeline depth when not stalled
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
            ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> i_out_valid)
        else $error("result missing after pipeline latency");

endmodule

bind catmull_rom_point_eval_top crpe_check u_crpe_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_pt.valid),
    .i_out_ready (o_pt.ready),
    .i_curve_x   (o_pt.curve_x),
    .i_curve_y   (o_pt.curve_y)
);

// ----- tb/catmull_rom_point_eval_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_point_eval_top_tb
// Self-checking bench for the Catmull-Rom curve point evaluator. A short
// table of corner requests runs first. Some rows carry hand-computed points
// and the rest are scored by a bit-true fixed-point Horner model. About 650
// random requests follow, with random gaps on the request and result
// channels, a long result-side stall that backs the pipeline up, and a
// stretch at full rate.
// ----------------------------------------------------------------------------
module catmull_rom_point_eval_top_tb;
    import crpe_pkg::*;

    localparam int CB        = 11;
    localparam int TB        = 16;
    localparam int N_RAND    = 650;
    localparam int N_DIR     = 18;
    localparam int IDLE_MAX  = 2000;
    localparam int HOLD_LEN  = 150;
    localparam int MAX_SHOWN = 10;

    typedef logic signed [OUT_BITS-1:0] t_crv_coord;

    typedef struct packed {
        logic [TB-1:0]         t;
        logic [0:3][CB-1:0]    px;
        logic [0:3][CB-1:0]    py;
    } t_crv_req;

    typedef struct packed {
        t_crv_coord x;
        t_crv_coord y;
    } t_crv_pt;

    // chk set: the point is typed in; clear: it comes from the model below
    typedef struct packed {
        logic     chk;
        t_crv_req req;
        t_crv_pt  pt;
    } t_crv_row;

    logic i_clk;
    logic i_rst_n;

    crpe_in_if #(.COORD_BITS(CB), .T_FRAC_BITS(TB)) pt_in ();
    crpe_out_if pt_out ();

    catmull_rom_point_eval_top #(
        .COORD_BITS  (CB),
        .T_FRAC_BITS (TB)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_in),
        .o_pt    (pt_out)
    );

    t_crv_pt pending_pts [$];
    int      n_err = 0;
    int      n_pts = 0;
    int      n_dir;
    int      n_rand;
    bit      rx_hold_req;
    bit      rx_steady;

    // Corner requests: zero and full-scale points, t at both ends, and
    // alternating points that give the deepest overshoot and undershoot
    // (the largest swing stays well inside the output range).
    t_crv_row dir_rows [0:N_DIR-1] = '{
        '{1, '{0,     '{0, 0, 0, 0},             '{0, 0, 0, 0}},             '{0, 0}},
        '{1, '{65535, '{0, 0, 0, 0},             '{0, 0, 0, 0}},             '{0, 0}},
        '{1, '{0,     '{2047, 2047, 2047, 2047}, '{2047, 2047, 2047, 2047}},
             '{524032, 524032}},
        '{1, '{65535, '{2047, 2047, 2047, 2047}, '{2047, 2047, 2047, 2047}},
             '{524032, 524032}},
        '{1, '{0,     '{0, 2047, 0, 2047},       '{2047, 0, 2047, 0}},       '{524032, 0}},
        '{1, '{0,     '{2047, 0, 2047, 0},       '{0, 2047, 0, 2047}},       '{0, 524032}},
        '{1, '{32768, '{1024, 1024, 1024, 1024}, '{1024, 1024, 1024, 1024}},
             '{262144, 262144}},
        '{1, '{1,     '{1, 1, 1, 1},             '{1, 1, 1, 1}},             '{256, 256}},
        '{0, '{32768, '{0, 2047, 2047, 0},       '{0, 2047, 2047, 0}},       '{0, 0}},
        '{0, '{32768, '{2047, 0, 0, 2047},       '{2047, 0, 0, 2047}},       '{0, 0}},
        '{0, '{65535, '{0, 0, 2047, 2047},       '{2047, 2047, 0, 0}},       '{0, 0}},
        '{0, '{65535, '{2047, 0, 2047, 0},       '{0, 2047, 0, 2047}},       '{0, 0}},
        '{0, '{1,     '{2047, 0, 2047, 0},       '{0, 2047, 0, 2047}},       '{0, 0}},
        '{0, '{16384, '{2047, 0, 0, 0},          '{0, 0, 0, 2047}},          '{0, 0}},
        '{0, '{49152, '{0, 2047, 0, 2047},       '{2047, 0, 2047, 0}},       '{0, 0}},
        '{0, '{32767, '{0, 682, 1365, 2047},     '{2047, 1365, 682, 0}},     '{0, 0}},
        '{0, '{65534, '{1, 2046, 1, 2046},       '{2046, 1, 2046, 1}},       '{0, 0}},
        '{0, '{43690, '{100, 300, 1500, 2000},   '{200, 1800, 50, 1900}},    '{0, 0}}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Rounding right shift, half toward +infinity
    function automatic longint crv_rnd(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // One axis: Horner over t with a 16-bit fraction accumulator, then
    // halve, drop to 8 fraction bits and saturate
    function automatic t_crv_coord crv_axis(input logic [TB-1:0] tq,
                                            input logic [CB-1:0] q0,
                                            input logic [CB-1:0] q1,
                                            input logic [CB-1:0] q2,
                                            input logic [CB-1:0] q3);
        longint c3;
        longint c2;
        longint c1;
        longint c0;
        longint tt;
        longint acc;
        c3  = -longint'(q0) + 3 * longint'(q1) - 3 * longint'(q2) + longint'(q3);
        c2  = 2 * longint'(q0) - 5 * longint'(q1) + 4 * longint'(q2) - longint'(q3);
        c1  = longint'(q2) - longint'(q0);
        c0  = 2 * longint'(q1);
        tt  = longint'(tq);
        acc = c3 <<< ACC_FRAC;
        acc = crv_rnd(acc * tt, TB) + (c2 <<< ACC_FRAC);
        acc = crv_rnd(acc * tt, TB) + (c1 <<< ACC_FRAC);
        acc = crv_rnd(acc * tt, TB) + (c0 <<< ACC_FRAC);
        acc = crv_rnd(acc, FIN_SH);
        if (acc > longint'(OUT_MAX)) begin
            acc = OUT_MAX;
        end else if (acc < longint'(OUT_MIN)) begin
            acc = OUT_MIN;
        end
        return acc[OUT_BITS-1:0];
    endfunction

    function automatic t_crv_pt crv_point(input t_crv_req r);
        t_crv_pt p;
        p.x = crv_axis(r.t, r.px[0], r.px[1], r.px[2], r.px[3]);
        p.y = crv_axis(r.t, r.py[0], r.py[1], r.py[2], r.py[3]);
        return p;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int crv_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Random request: uniform, clustered like a real curve, or at extremes
    function automatic t_crv_req crv_rand_req();
        t_crv_req r;
        int       sel;
        int       bx;
        int       by;
        int       v;
        int       k;
        sel = $urandom_range(0, 3);
        r.t = TB'($urandom_range(0, 65535));
        for (k = 0; k < 4; k++) begin
            r.px[k] = CB'($urandom_range(0, 2047));
            r.py[k] = CB'($urandom_range(0, 2047));
        end
        if (sel == 2) begin
            bx = $urandom_range(0, 2047);
            by = $urandom_range(0, 2047);
            for (k = 0; k < 4; k++) begin
                v = bx + int'($urandom_range(0, 128)) - 64;
                r.px[k] = CB'((v < 0) ? 0 : (v > 2047) ? 2047 : v);
                v = by + int'($urandom_range(0, 128)) - 64;
                r.py[k] = CB'((v < 0) ? 0 : (v > 2047) ? 2047 : v);
            end
        end else if (sel == 3) begin
            for (k = 0; k < 4; k++) begin
                r.px[k] = $urandom_range(0, 1) ? CB'(2047 - $urandom_range(0, 1))
                                               : CB'($urandom_range(0, 1));
                r.py[k] = $urandom_range(0, 1) ? CB'(2047 - $urandom_range(0, 1))
                                               : CB'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 1)) begin
                r.t = $urandom_range(0, 1) ? TB'(65535 - $urandom_range(0, 1))
                                           : TB'($urandom_range(0, 1));
            end
        end
        return r;
    endfunction

    task automatic note_err(input string msg);
        n_err++;
        if (n_err <= MAX_SHOWN) begin
            $display("[%0t] %s", $time, msg);
        end
    endtask

    // Offer one request after an idle gap of the given length; entered and left at a falling edge
    task automatic send_req(input t_crv_req r, input bit chk, input t_crv_pt typed,
                            input int gap);
        t_crv_pt exp_pt;
        if (gap > 0) begin
            pt_in.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pt_in.valid   <= 1'b1;
        pt_in.t_param <= r.t;
        pt_in.p0_x    <= r.px[0];
        pt_in.p0_y    <= r.py[0];
        pt_in.p1_x    <= r.px[1];
        pt_in.p1_y    <= r.py[1];
        pt_in.p2_x    <= r.px[2];
        pt_in.p2_y    <= r.py[2];
        pt_in.p3_x    <= r.px[3];
        pt_in.p3_y    <= r.py[3];
        do begin
            @(posedge i_clk);
        end while (!pt_in.ready);
        exp_pt      = chk ? typed : crv_point(r);
        pending_pts = {pending_pts, exp_pt};
        @(negedge i_clk);
    endtask

    // Result side: random back-pressure, a long hold on request
    initial begin
        int off_left;
        bit hold_done;
        off_left     = 0;
        hold_done    = 1'b0;
        pt_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req && !hold_done) begin
                hold_done = 1'b1;
                off_left  = HOLD_LEN;
            end
            if (off_left > 0) begin
                pt_out.ready <= 1'b0;
                off_left--;
            end else begin
                pt_out.ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 2) == 0) begin
                    off_left = crv_gap();
                end
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_crv_pt want;
        if (i_rst_n && pt_out.valid && pt_out.ready) begin
            n_pts++;
            if (pending_pts.size() == 0) begin
                note_err($sformatf("unexpected point x=%0d y=%0d",
                                   pt_out.curve_x, pt_out.curve_y));
            end else begin
                want = pending_pts.pop_front();
                if (pt_out.curve_x !== want.x || pt_out.curve_y !== want.y) begin
                    note_err($sformatf("point %0d: expected x=%0d y=%0d, got x=%0d y=%0d",
                                       n_pts, want.x, want.y,
                                       pt_out.curve_x, pt_out.curve_y));
                end
            end
        end
    end

    // Watchdog: cycles with no handshake on either channel
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_MAX) begin
            @(posedge i_clk);
            if ((pt_in.valid && pt_in.ready) || (pt_out.valid && pt_out.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("watchdog: no handshake for %0d cycles, %0d points pending",
                 IDLE_MAX, pending_pts.size());
        $display("catmull_rom_point_eval_top regression: fail");
        $finish;
    end

    // Stimulus
    initial begin
        t_crv_req r;
        int       i;
        int       gap;
        n_dir         = 0;
        n_rand        = 0;
        rx_hold_req   = 1'b0;
        rx_steady     = 1'b0;
        i_rst_n       = 1'b0;
        pt_in.valid   = 1'b0;
        pt_in.t_param = '0;
        pt_in.p0_x    = '0;
        pt_in.p0_y    = '0;
        pt_in.p1_x    = '0;
        pt_in.p1_y    = '0;
        pt_in.p2_x    = '0;
        pt_in.p2_y    = '0;
        pt_in.p3_x    = '0;
        pt_in.p3_y    = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Corner table
        for (i = 0; i < N_DIR; i++) begin
            send_req(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].pt, crv_gap());
            n_dir++;
        end
        // Drain before the random part
        pt_in.valid <= 1'b0;
        wait (pending_pts.size() == 0);
        @(negedge i_clk);

        for (i = 0; i < N_RAND; i++) begin
            r   = crv_rand_req();
            gap = crv_gap();
            // Long result stall while requests keep coming back to back
            if (i == 150) begin
                rx_hold_req = 1'b1;
            end
            if (i >= 150 && i < 190) begin
                gap = 0;
            end
            // Full-rate stretch on both sides
            if (i == 300) begin
                rx_steady = 1'b1;
            end
            if (i >= 300 && i < 450) begin
                gap = 0;
            end
            // Sender pause until the pipeline is empty
            if (i == 450) begin
                rx_steady = 1'b0;
                pt_in.valid <= 1'b0;
                wait (pending_pts.size() == 0);
                @(negedge i_clk);
            end
            send_req(r, 1'b0, '0, gap);
            n_rand++;
        end
        pt_in.valid <= 1'b0;

        wait (pending_pts.size() == 0);
        repeat (4 * NUM_STAGES) @(posedge i_clk);
        $display("ran %0d corner and %0d random requests, %0d curve points scored,",
                 n_dir, n_rand, n_pts);
        $display("including a %0d-cycle result stall and a full-rate stretch; %0d mismatches",
                 HOLD_LEN, n_err);
        if (n_err == 0) begin
            $display("catmull_rom_point_eval_top regression: pass");
        end else begin
            $display("catmull_rom_point_eval_top regression: fail");
        end
        $finish;
    end

endmodule
